// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the text console writer.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion clocked on the rising edge and switched off while reset is held.
`define TCW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Assertion clocked on the rising edge that also holds through reset.
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console writer: command codes, control
// characters, reset attribute and the packed input and result words.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  // Default screen geometry.
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // One cell holds the attribute byte over the glyph byte.
  localparam int CELL_W = 16;

  // Command codes.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Characters with a control meaning, and the blank glyph.
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Attribute after reset.
  localparam logic [7:0] ATTR_RESET = 8'h07;

  // Command word.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
  } out_word_t;

  // Actions that one put step asks of the controller.
  typedef struct packed {
    logic wr_en;
    logic wr_blank;
    logic scroll;
  } put_flags_t;

endpackage

`default_nettype wire

// ===== rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write on enable; the addressed entry is read every cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/tcw_cursor.sv =====
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor step of a put command: decodes the byte, gives the next cursor
// position, the cell write it causes and whether the screen must scroll.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_cursor #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic [$clog2(COLUMNS)-1:0] col,
  input  wire logic [$clog2(ROWS)-1:0]    row,
  input  wire logic [7:0]                 char_code,
  output tcw_pkg::put_flags_t             flags,
  output logic [$clog2(COLUMNS)-1:0]      wr_col,
  output logic [$clog2(COLUMNS)-1:0]      next_col,
  output logic [$clog2(ROWS)-1:0]         next_row
);

  import tcw_pkg::*;

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  logic [COL_W:0] col_inc;
  logic [COL_W:0] col_tab;
  logic           wrap;

  // Candidate columns for a printed byte and for a tab stop.
  assign col_inc = {1'b0, col} + (COL_W+1)'(1);
  assign col_tab = ({1'b0, col} + (COL_W+1)'(4)) & ~(COL_W+1)'(3);

  // Byte decode, then the line advance it causes.
  always_comb begin
    flags    = '0;
    wr_col   = col;
    next_col = col;
    next_row = row;
    wrap     = 1'b0;
    case (char_code)
      CH_NEWLINE: begin
        next_col = '0;
        wrap     = 1'b1;
      end
      CH_BACKSPACE: begin
        if (col != '0) begin
          next_col       = col - COL_W'(1);
          wr_col         = col - COL_W'(1);
          flags.wr_en    = 1'b1;
          flags.wr_blank = 1'b1;
        end
      end
      CH_TAB: begin
        if (col_tab >= (COL_W+1)'(COLUMNS)) begin
          next_col = '0;
          wrap     = 1'b1;
        end else begin
          next_col = col_tab[COL_W-1:0];
        end
      end
      default: begin
        flags.wr_en = 1'b1;
        if (col_inc >= (COL_W+1)'(COLUMNS)) begin
          next_col = '0;
          wrap     = 1'b1;
        end else begin
          next_col = col_inc[COL_W-1:0];
        end
      end
    endcase

    // Line advance; past the last row the cursor stays and the screen scrolls.
    if (wrap) begin
      if (row == ROW_W'(ROWS - 1)) begin
        flags.scroll = 1'b1;
      end else begin
        next_row = row + ROW_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/text_console_writer_top.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console: put, read and clear commands on a screen
// memory that scrolls through a ring pointer on its top row.
// ----------------------------------------------------------------------------
// Usage:
//   A command word is taken at a rising edge with start high and busy low.
//   Every command gives one result word on out_word, shown for exactly one
//   cycle with out_strobe high; the receiver cannot hold it off.
//   The attribute register is written through cfg_we and cfg_wdata; write it
//   only while the block is idle, which the block itself does not enforce.
// Command flow:
//   Put without scroll, read, and the unused command go from the execute
//   state to the done or read-data state, which gives the result strobe; the
//   next word can be taken in the strobe cycle.
//   A put that scrolls first blanks the new bottom row one cell a cycle
//   through the single RAM port; the rows themselves never move.
//   Clear blanks every cell one per cycle.
// Reset:
//   rst_n (synchronous) homes the cursor, sets the attribute to 0x07 and
//   starts a clearing pass, during which busy is high; no result word
//   comes out of it.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer_top #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire tcw_pkg::in_word_t in_word,
  output logic                   out_strobe,
  output tcw_pkg::out_word_t     out_word,
  input  wire logic              cfg_we,
  input  wire logic [7:0]        cfg_wdata
);

  import tcw_pkg::*;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = ROWS * (2 ** COL_W);

  // Controller states.
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EXEC      = 3'd1;
  localparam logic [2:0] S_RDATA     = 3'd2;
  localparam logic [2:0] S_SWEEP_ALL = 3'd3;
  localparam logic [2:0] S_SWEEP_ROW = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  logic [2:0]        state_r, state_nxt;
  in_word_t          in_r, in_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ROW_W-1:0]  sw_row_r, sw_row_nxt;
  logic [COL_W-1:0]  sw_col_r, sw_col_nxt;
  logic              clr_r, clr_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [7:0]        attr_r, attr_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] mem_rdata;

  put_flags_t        put_flags;
  logic [COL_W-1:0]  put_wr_col;
  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;

  logic              rd_ok;
  logic [ROW_W-1:0]  rd_row;
  logic [COL_W-1:0]  rd_col;
  logic              sw_col_last;
  logic              sw_row_last;
  logic [ROW_W-1:0]  top_inc;

  // Logical row to physical row through the ring top pointer.
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] base,
                                                input logic [ROW_W-1:0] ofs);
    logic [ROW_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  // Screen memory.
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Cursor step for put commands.
  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .col       (col_r),
    .row       (row_r),
    .char_code (in_r.char_code),
    .flags     (put_flags),
    .wr_col    (put_wr_col),
    .next_col  (put_col),
    .next_row  (put_row)
  );

  // Read address and its bounds check.
  assign rd_ok  = (int'(in_r.read_row) < ROWS) && (int'(in_r.read_col) < COLUMNS);
  assign rd_row = ROW_W'(in_r.read_row);
  assign rd_col = COL_W'(in_r.read_col);

  assign sw_col_last = (sw_col_r == COL_W'(COLUMNS - 1));
  assign sw_row_last = (sw_row_r == ROW_W'(ROWS - 1));
  assign top_inc     = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + ROW_W'(1);

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // Attribute register.
  assign attr_nxt = cfg_we ? cfg_wdata : attr_r;

  // Command sequencer and memory port.
  always_comb begin
    state_nxt      = state_r;
    in_nxt         = in_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    top_nxt        = top_r;
    sw_row_nxt     = sw_row_r;
    sw_col_nxt     = sw_col_r;
    clr_nxt        = clr_r;
    rd_ok_nxt      = rd_ok_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    mem_we         = 1'b0;
    mem_addr       = {sw_row_r, sw_col_r};
    mem_wdata      = {attr_r, CH_SPACE};

    case (state_r)
      S_IDLE: begin
        if (start) begin
          in_nxt    = in_word;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        case (in_r.cmd)
          CMD_PUT: begin
            mem_we    = put_flags.wr_en;
            mem_addr  = {phys_row(top_r, row_r), put_wr_col};
            mem_wdata = put_flags.wr_blank ? {attr_r, CH_SPACE}
                                           : {attr_r, in_r.char_code};
            col_nxt   = put_col;
            row_nxt   = put_row;
            if (put_flags.scroll) begin
              // The old top row becomes the new bottom row and is blanked.
              sw_row_nxt = top_r;
              sw_col_nxt = '0;
              top_nxt    = top_inc;
              state_nxt  = S_SWEEP_ROW;
            end else begin
              state_nxt = S_DONE;
            end
          end
          CMD_READ: begin
            mem_addr  = {phys_row(top_r, rd_row), rd_col};
            rd_ok_nxt = rd_ok;
            state_nxt = S_RDATA;
          end
          CMD_CLEAR: begin
            col_nxt    = '0;
            row_nxt    = '0;
            sw_row_nxt = '0;
            sw_col_nxt = '0;
            clr_nxt    = 1'b1;
            state_nxt  = S_SWEEP_ALL;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_RDATA: begin
        // Registered read data of the cell addressed in the last cycle.
        out_strobe_nxt          = 1'b1;
        out_word_nxt.cursor_col = 7'(col_r);
        out_word_nxt.cursor_row = 5'(row_r);
        out_word_nxt.cell_char  = rd_ok_r ? mem_rdata[7:0] : 8'h00;
        out_word_nxt.cell_attr  = rd_ok_r ? mem_rdata[15:8] : 8'h00;
        state_nxt               = S_IDLE;
      end

      S_SWEEP_ALL: begin
        // Blank every cell; the pass after reset uses the reset attribute.
        mem_we    = 1'b1;
        mem_wdata = {(clr_r ? attr_r : ATTR_RESET), CH_SPACE};
        if (sw_col_last) begin
          sw_col_nxt = '0;
          if (sw_row_last) begin
            sw_row_nxt = '0;
            clr_nxt    = 1'b0;
            state_nxt  = clr_r ? S_DONE : S_IDLE;
          end else begin
            sw_row_nxt = sw_row_r + ROW_W'(1);
          end
        end else begin
          sw_col_nxt = sw_col_r + COL_W'(1);
        end
      end

      S_SWEEP_ROW: begin
        mem_we = 1'b1;
        if (sw_col_last) begin
          sw_col_nxt = '0;
          state_nxt  = S_DONE;
        end else begin
          sw_col_nxt = sw_col_r + COL_W'(1);
        end
      end

      S_DONE: begin
        out_strobe_nxt          = 1'b1;
        out_word_nxt.cursor_col = 7'(col_r);
        out_word_nxt.cursor_row = 5'(row_r);
        out_word_nxt.cell_char  = 8'h00;
        out_word_nxt.cell_attr  = 8'h00;
        state_nxt               = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP_ALL;
      col_r        <= '0;
      row_r        <= '0;
      top_r        <= '0;
      sw_row_r     <= '0;
      sw_col_r     <= '0;
      clr_r        <= 1'b0;
      rd_ok_r      <= 1'b0;
      attr_r       <= ATTR_RESET;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      top_r        <= top_nxt;
      sw_row_r     <= sw_row_nxt;
      sw_col_r     <= sw_col_nxt;
      clr_r        <= clr_nxt;
      rd_ok_r      <= rd_ok_nxt;
      attr_r       <= attr_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire tcw_pkg::out_word_t out_word
);

  logic cursor_ok;

  // The reported cursor lies on the screen.
  assign cursor_ok = (int'(out_word.cursor_col) < COLUMNS) &&
                     (int'(out_word.cursor_row) < ROWS);

  // Reset always starts the clearing pass, so the block is busy after it.
  `TCW_ASSERT_ALWAYS(a_busy_after_reset, clk, !rst_n |=> busy, "not busy after reset")

  // An accepted word keeps the block busy in the next cycle.
  `TCW_ASSERT(a_busy_after_accept, clk, rst_n, start && !busy |=> busy, "accept not held off")

  // A result word only follows a busy cycle, and lasts one cycle.
  `TCW_ASSERT(a_strobe_after_busy, clk, rst_n, out_strobe |-> $past(busy), "stray result")
  `TCW_ASSERT(a_strobe_single, clk, rst_n, out_strobe |=> !out_strobe, "repeated result")

  // Every result word reports a cursor on the screen.
  `TCW_ASSERT(a_cursor_on_screen, clk, rst_n, out_strobe |-> cursor_ok, "cursor off screen")

endmodule

bind text_console_writer_top tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);

`default_nettype wire
